FILE: design/mexp_pkg.sv
// Package for the modular exponentiation block: widths, datapath operations and link types.
package mexp_pkg;

    // Default field widths.
    localparam int MOD_BITS = 31;
    localparam int EXP_BITS = 32;
    // The base input is always a 32-bit word.
    localparam int BASE_BITS = 32;

    // Operations the controller issues to the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_STEP_RED,
        OP_STEP_MUL,
        OP_SAVE_SQ,
        OP_INIT_MUL,
        OP_INIT_SQ,
        OP_ACC_INIT_SQ,
        OP_SQ_SHIFT
    } dp_op_t;

    // Command bundle from controller to datapath.
    typedef struct packed {
        dp_op_t op;
        logic   publish;
    } dp_cmd_t;

    // Status bundle from datapath to controller.
    typedef struct packed {
        logic e_zero;
        logic e_lsb;
    } dp_status_t;

endpackage

FILE: design/mexp_dp.sv
// Datapath of the modular exponentiation block: operand registers and the shift-and-add modular multiplier.
module mexp_dp #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS,
    parameter int EXP_BITS = mexp_pkg::EXP_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [MOD_BITS-1:0]            modulus,
    input  logic [mexp_pkg::BASE_BITS-1:0] base_value,
    input  logic [EXP_BITS-1:0]            exponent,
    input  mexp_pkg::dp_cmd_t              cmd,
    output mexp_pkg::dp_status_t           status,
    output logic [MOD_BITS-1:0]            power_result
);

    localparam int SCAN_W = mexp_pkg::BASE_BITS;
    localparam int PAD_W  = SCAN_W - MOD_BITS;

    logic [MOD_BITS-1:0] modulus_reg;
    logic [MOD_BITS-1:0] r_reg, r_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;
    logic [MOD_BITS-1:0] power_result_reg, power_result_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;

    logic                scan_msb;
    logic [MOD_BITS:0]   red_t;
    logic [MOD_BITS+1:0] red_sub;
    logic [MOD_BITS-1:0] red_r;
    logic [MOD_BITS+1:0] mul_t;
    logic [MOD_BITS+2:0] mul_sub1;
    logic [MOD_BITS+2:0] mul_sub2;
    logic [MOD_BITS-1:0] mul_r;

    // Modulus register; a written zero is kept as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= '1;
        end
        else if (cfg_write)
        begin
            modulus_reg <= (modulus == '0) ? MOD_BITS'(1) : modulus;
        end
    end

    assign scan_msb = scan_reg[SCAN_W-1];

    // One step of reducing the base: shift in the next bit, subtract once.
    always_comb
    begin
        red_t   = {r_reg, scan_msb};
        red_sub = {1'b0, red_t} - {2'b00, modulus_reg};
        red_r   = red_sub[MOD_BITS+1] ? red_t[MOD_BITS-1:0] : red_sub[MOD_BITS-1:0];
    end

    // One step of the interleaved modular product: 2r + bit*sq, minus m or 2m.
    always_comb
    begin
        mul_t    = {1'b0, r_reg, 1'b0} + {2'b00, (scan_msb ? sq_reg : '0)};
        mul_sub1 = {1'b0, mul_t} - {3'b000, modulus_reg};
        mul_sub2 = {1'b0, mul_t} - {2'b00, modulus_reg, 1'b0};
        if (!mul_sub2[MOD_BITS+2])
        begin
            mul_r = mul_sub2[MOD_BITS-1:0];
        end
        else if (!mul_sub1[MOD_BITS+2])
        begin
            mul_r = mul_sub1[MOD_BITS-1:0];
        end
        else
        begin
            mul_r = mul_t[MOD_BITS-1:0];
        end
    end

    // Operation decoder for the operand registers.
    always_comb
    begin
        r_next            = r_reg;
        acc_next          = acc_reg;
        sq_next           = sq_reg;
        e_next            = e_reg;
        scan_next         = scan_reg;
        power_result_next = power_result_reg;
        unique case (cmd.op)
            mexp_pkg::OP_NONE:
            begin
            end
            mexp_pkg::OP_LOAD:
            begin
                r_next    = '0;
                acc_next  = MOD_BITS'(1);
                e_next    = exponent;
                scan_next = base_value;
            end
            mexp_pkg::OP_STEP_RED:
            begin
                r_next    = red_r;
                scan_next = {scan_reg[SCAN_W-2:0], 1'b0};
            end
            mexp_pkg::OP_STEP_MUL:
            begin
                r_next    = mul_r;
                scan_next = {scan_reg[SCAN_W-2:0], 1'b0};
            end
            mexp_pkg::OP_SAVE_SQ:
            begin
                sq_next = r_reg;
            end
            mexp_pkg::OP_INIT_MUL:
            begin
                r_next    = '0;
                scan_next = {acc_reg, {PAD_W{1'b0}}};
            end
            mexp_pkg::OP_INIT_SQ:
            begin
                r_next    = '0;
                scan_next = {sq_reg, {PAD_W{1'b0}}};
            end
            mexp_pkg::OP_ACC_INIT_SQ:
            begin
                acc_next  = r_reg;
                r_next    = '0;
                scan_next = {sq_reg, {PAD_W{1'b0}}};
            end
            mexp_pkg::OP_SQ_SHIFT:
            begin
                sq_next = r_reg;
                e_next  = e_reg >> 1;
            end
            default:
            begin
            end
        endcase
        if (cmd.publish)
        begin
            power_result_next = acc_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        r_reg            <= r_next;
        acc_reg          <= acc_next;
        sq_reg           <= sq_next;
        e_reg            <= e_next;
        scan_reg         <= scan_next;
        power_result_reg <= power_result_next;
    end

    assign status.e_zero = (e_reg == '0);
    assign status.e_lsb  = e_reg[0];
    assign power_result  = power_result_reg;

`ifndef SYNTH
    // Every reduction or product step leaves a value below the modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.op) == mexp_pkg::OP_STEP_MUL || $past(cmd.op) == mexp_pkg::OP_STEP_RED)
        |-> (r_reg < modulus_reg))
    else $error("partial remainder not reduced");

    // A saved running product is always reduced.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.op) == mexp_pkg::OP_ACC_INIT_SQ) |-> (acc_reg < modulus_reg))
    else $error("running product not reduced");
`endif

endmodule

FILE: design/mexp_ctrl.sv
// Controller of the modular exponentiation block: sequencing state machine and output valid.
module mexp_ctrl #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  mexp_pkg::dp_status_t status,
    output mexp_pkg::dp_cmd_t    cmd
);

    localparam int CNT_W = $clog2(mexp_pkg::BASE_BITS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_RED_DONE,
        ST_CHECK,
        ST_MUL,
        ST_MUL_DONE,
        ST_SQ,
        ST_SQ_DONE,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state, counter and datapath command.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.op      = mexp_pkg::OP_NONE;
        cmd.publish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = mexp_pkg::OP_LOAD;
                    cnt_next   = CNT_W'(mexp_pkg::BASE_BITS - 1);
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.op   = mexp_pkg::OP_STEP_RED;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_RED_DONE;
                end
            end
            ST_RED_DONE:
            begin
                cmd.op     = mexp_pkg::OP_SAVE_SQ;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cnt_next = CNT_W'(MOD_BITS - 1);
                if (status.e_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (status.e_lsb)
                begin
                    cmd.op     = mexp_pkg::OP_INIT_MUL;
                    state_next = ST_MUL;
                end
                else
                begin
                    cmd.op     = mexp_pkg::OP_INIT_SQ;
                    state_next = ST_SQ;
                end
            end
            ST_MUL:
            begin
                cmd.op   = mexp_pkg::OP_STEP_MUL;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_MUL_DONE;
                end
            end
            ST_MUL_DONE:
            begin
                cmd.op     = mexp_pkg::OP_ACC_INIT_SQ;
                cnt_next   = CNT_W'(MOD_BITS - 1);
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op   = mexp_pkg::OP_STEP_MUL;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SQ_DONE;
                end
            end
            ST_SQ_DONE:
            begin
                cmd.op     = mexp_pkg::OP_SQ_SHIFT;
                state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is published, cleared when it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // A result is published only into a free or draining output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || !out_stall))
    else $error("result published over a pending item");

    // An accepted item blocks the input until its computation ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accepting an item");
`endif

endmodule

FILE: design/modular_exponentiation.sv
// Top level of the modular exponentiation block: base^exponent mod modulus.
//
// Usage: write the modulus with cfg_write while the block is idle; zero acts as one.
// Reset sets the modulus to 2^MOD_BITS-1 and empties the block.
// Input channel: base_value and exponent are taken when in_valid is high and
// in_stall is low. One item is worked on at a time; in_stall stays high until it ends.
// The base is first reduced, one base bit per cycle. Each exponent bit up to the
// highest set one then costs a squaring plus, if set, a product, both done by one
// shift-and-add modular multiplier that handles one operand bit per cycle.
// Output channel: power_result is held with out_valid until out_stall is low.
// A stalled result waits in the output register while the next item is
// accepted and computed; that item waits only at its end for the register.
module modular_exponentiation #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS,
    parameter int EXP_BITS = mexp_pkg::EXP_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [MOD_BITS-1:0]            modulus,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mexp_pkg::BASE_BITS-1:0] base_value,
    input  logic [EXP_BITS-1:0]            exponent,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [MOD_BITS-1:0]            power_result
);

    mexp_pkg::dp_cmd_t    cmd;
    mexp_pkg::dp_status_t status;

    // Sequencer.
    mexp_ctrl #(
        .MOD_BITS (MOD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Operand registers and modular multiplier.
    mexp_dp #(
        .MOD_BITS (MOD_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .modulus      (modulus),
        .base_value   (base_value),
        .exponent     (exponent),
        .cmd          (cmd),
        .status       (status),
        .power_result (power_result)
    );

endmodule
